// File: hdl/spa_pkg.sv
package spa_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned SplitMin    = 40;

  localparam int unsigned SizeW  = 25;
  localparam int unsigned NeedW  = 26;
  localparam int unsigned OffW   = 24;
  localparam int unsigned AlignW = 13;
  localparam int unsigned LiveW  = 7;
  localparam int unsigned AddrW  = 4;

  localparam logic [SizeW-1:0]  PoolReset  = SizeW'(1048576);
  localparam logic [SizeW-1:0]  PoolLimit  = SizeW'(16777216);
  localparam logic [AlignW-1:0] AlignReset = AlignW'(64);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_e;

  typedef enum logic [1:0] {
    REG_FIT   = 2'd0,
    REG_POOL  = 2'd1,
    REG_ALIGN = 2'd2,
    REG_NONE  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SizeW-1:0]  request_bytes;
    logic [AlignW-1:0] alignment;
    logic [OffW-1:0]   free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OffW-1:0]  alloc_offset;
    logic [SizeW-1:0] used_bytes;
    logic [SizeW-1:0] available_bytes;
    logic [LiveW-1:0] live_allocations;
    logic [SizeW-1:0] peak_bytes;
  } res_t;

  typedef struct packed {
    logic             free;
    logic [SizeW-1:0] size;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_COPY_CHK, S_COPY_RD,
    S_COPY_WR, S_W_SPLIT, S_W_PICK, S_NEXT_RD, S_NEXT_WT, S_MERGE, S_RST, S_DONE
  } state_e;

  typedef struct packed {
    logic    init;
    logic    load;
    logic    scan;
    logic    decide;
    logic    copy_rd;
    logic    copy_wr;
    logic    w_split;
    logic    w_pick;
    logic    next_rd;
    logic    next_wt;
    logic    merge;
    logic    pool_rst;
    logic    done;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       need_zero;
    logic       stop_hit;
    logic       scan_end;
    logic       found;
    logic       split_ok;
    logic       copy_more;
    logic       copy_up;
    logic       shift_nz;
  } stat_t;

endpackage

// File: hdl/spa_ram.sv
module spa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/spa_ctrl.sv
module spa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  spa_pkg::stat_t st_i,
  output spa_pkg::cmd_t  cmd_o,
  output logic           busy
);

  spa_pkg::state_e  state_q, state_d;
  spa_pkg::status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spa_pkg::S_INIT;
      code_q  <= spa_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    cmd_o      = '0;
    cmd_o.code = code_q;
    busy       = (state_q != spa_pkg::S_IDLE);
    unique case (state_q)
      spa_pkg::S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = spa_pkg::S_IDLE;
      end
      spa_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          code_d     = spa_pkg::ST_OK;
          state_d    = spa_pkg::S_DISPATCH;
        end
      end
      spa_pkg::S_DISPATCH: begin
        unique case (st_i.kind)
          spa_pkg::KIND_ALLOC: begin
            if (st_i.need_zero) begin
              code_d  = spa_pkg::ST_INVALID;
              state_d = spa_pkg::S_DONE;
            end else begin
              state_d = spa_pkg::S_SCAN;
            end
          end
          spa_pkg::KIND_FREE:  state_d = spa_pkg::S_SCAN;
          spa_pkg::KIND_RESET: state_d = spa_pkg::S_RST;
          default: begin
            code_d  = spa_pkg::ST_INVALID;
            state_d = spa_pkg::S_DONE;
          end
        endcase
      end
      spa_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.stop_hit || st_i.scan_end) begin
          state_d = spa_pkg::S_DECIDE;
        end
      end
      spa_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (!st_i.found) begin
          code_d  = (st_i.kind == spa_pkg::KIND_ALLOC) ? spa_pkg::ST_NOMEM
                                                        : spa_pkg::ST_INVALID;
          state_d = spa_pkg::S_DONE;
        end else if (st_i.kind != spa_pkg::KIND_ALLOC) begin
          state_d = spa_pkg::S_NEXT_RD;
        end else if (st_i.split_ok) begin
          state_d = spa_pkg::S_COPY_CHK;
        end else begin
          state_d = spa_pkg::S_W_PICK;
        end
      end
      spa_pkg::S_COPY_CHK: begin
        if (st_i.copy_more) begin
          state_d = spa_pkg::S_COPY_RD;
        end else if (st_i.copy_up) begin
          state_d = spa_pkg::S_W_SPLIT;
        end else begin
          state_d = spa_pkg::S_DONE;
        end
      end
      spa_pkg::S_COPY_RD: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = spa_pkg::S_COPY_WR;
      end
      spa_pkg::S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = spa_pkg::S_COPY_CHK;
      end
      spa_pkg::S_W_SPLIT: begin
        cmd_o.w_split = 1'b1;
        state_d       = spa_pkg::S_W_PICK;
      end
      spa_pkg::S_W_PICK: begin
        cmd_o.w_pick = 1'b1;
        state_d      = spa_pkg::S_DONE;
      end
      spa_pkg::S_NEXT_RD: begin
        cmd_o.next_rd = 1'b1;
        state_d       = spa_pkg::S_NEXT_WT;
      end
      spa_pkg::S_NEXT_WT: begin
        cmd_o.next_wt = 1'b1;
        state_d       = spa_pkg::S_MERGE;
      end
      spa_pkg::S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = st_i.shift_nz ? spa_pkg::S_COPY_CHK : spa_pkg::S_DONE;
      end
      spa_pkg::S_RST: begin
        cmd_o.pool_rst = 1'b1;
        state_d        = spa_pkg::S_DONE;
      end
      spa_pkg::S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = spa_pkg::S_IDLE;
      end
      default: state_d = spa_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hdl/spa_dpath.sv
module spa_dpath #(
  parameter int unsigned MAX_SEGMENTS = spa_pkg::MaxSegments,
  parameter int unsigned SPLIT_MIN    = spa_pkg::SplitMin
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spa_pkg::req_t               req_i,
  input  logic [1:0]                  fit_i,
  input  logic [spa_pkg::SizeW-1:0]   pool_cfg_i,
  input  logic [spa_pkg::AlignW-1:0]  align_cfg_i,
  input  spa_pkg::cmd_t               cmd_i,
  output spa_pkg::stat_t              st_o,
  output spa_pkg::res_t               res_o,
  output logic                        res_valid_o
);

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned SW = spa_pkg::SizeW;
  localparam int unsigned NW = spa_pkg::NeedW;
  localparam logic [NW:0] SplitK = (NW+1)'(SPLIT_MIN);
  localparam logic [CW-1:0] MaxK = CW'(MAX_SEGMENTS);

  logic [1:0]    kind_q;
  logic [NW-1:0] need_q;
  logic [spa_pkg::OffW-1:0] target_q;
  logic [CW-1:0] count_q, live_q, scan_q, chk_idx_q, pick_q, src_q, dst_q, lim_q;
  logic [SW-1:0] used_q, peak_q, pool_q, cur_q, pick_sz_q, pick_off_q, mark_q;
  logic [SW-1:0] prev_sz_q, nxt_sz_q;
  logic          chk_v_q, found_q, prev_free_q, nxt_free_q, has_next_q, split_q, up_q;
  spa_pkg::res_t res_q;
  logic          res_v_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  spa_pkg::seg_t        ram_wdata, ent;
  logic [$bits(spa_pkg::seg_t)-1:0] ram_rdata;

  logic [spa_pkg::AlignW-1:0] align_eff;
  logic [NW-1:0] align_m1, need_c;
  logic          fits, take, match, is_alloc, hit, split_ok;
  logic [SW-1:0] pool_new, granted, used_add;
  logic [CW-1:0] pick_p1, pick_p2, pick_m1;

  spa_ram #(.Width($bits(spa_pkg::seg_t)), .Depth(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ent       = spa_pkg::seg_t'(ram_rdata);
    align_eff = (req_i.alignment != '0) ? req_i.alignment : align_cfg_i;
    if (align_eff == '0) begin
      align_eff = spa_pkg::AlignW'(1);
    end
    align_m1 = NW'(align_eff) - NW'(1);
    need_c   = ({1'b0, req_i.request_bytes} + align_m1) & ~align_m1;

    is_alloc = (kind_q == spa_pkg::KIND_ALLOC);
    fits     = ent.free && ({1'b0, ent.size} >= need_q);
    unique case (fit_i)
      spa_pkg::FIT_FIRST: take = fits;
      spa_pkg::FIT_BEST:  take = fits && (!found_q || ent.size < mark_q);
      spa_pkg::FIT_WORST: take = fits && (ent.size > mark_q);
      default:            take = 1'b0;
    endcase
    match = (cur_q == {1'b0, target_q}) && !ent.free;
    hit   = chk_v_q && (is_alloc ? take : match);

    split_ok = ({2'b00, pick_sz_q} > ({1'b0, need_q} + SplitK)) && (count_q < MaxK);
    pick_p1  = pick_q + CW'(1);
    pick_p2  = pick_q + CW'(2);
    pick_m1  = pick_q - CW'(1);

    if (pool_cfg_i == '0) begin
      pool_new = SW'(1);
    end else if (pool_cfg_i > spa_pkg::PoolLimit) begin
      pool_new = spa_pkg::PoolLimit;
    end else begin
      pool_new = pool_cfg_i;
    end
    granted  = split_q ? need_q[SW-1:0] : pick_sz_q;
    used_add = used_q + granted;

    st_o.kind      = kind_q;
    st_o.need_zero = (need_q == '0);
    st_o.stop_hit  = chk_v_q && (is_alloc ? (take && fit_i == spa_pkg::FIT_FIRST) : match);
    st_o.scan_end  = chk_v_q && (chk_idx_q == count_q - CW'(1));
    st_o.found     = found_q;
    st_o.split_ok  = split_ok;
    st_o.copy_more = up_q ? (dst_q > lim_q) : (src_q < lim_q);
    st_o.copy_up   = up_q;
    st_o.shift_nz  = prev_free_q | nxt_free_q;
  end

  // Read port: scan pointer, copy source or the entry after the pick.
  always_comb begin
    priority if (cmd_i.copy_rd) begin
      ram_raddr = src_q[AW-1:0];
    end else if (cmd_i.next_rd) begin
      ram_raddr = pick_p1[AW-1:0];
    end else begin
      ram_raddr = scan_q[AW-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick_q[AW-1:0];
    ram_wdata = '{free: 1'b1, size: pick_sz_q};
    priority if (cmd_i.init) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = '{free: 1'b1, size: pool_q};
    end else if (cmd_i.pool_rst) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = '{free: 1'b1, size: pool_new};
    end else if (cmd_i.copy_wr) begin
      ram_we    = 1'b1;
      ram_waddr = dst_q[AW-1:0];
      ram_wdata = ent;
    end else if (cmd_i.w_split) begin
      ram_we    = 1'b1;
      ram_waddr = pick_p1[AW-1:0];
      ram_wdata = '{free: 1'b1, size: pick_sz_q - need_q[SW-1:0]};
    end else if (cmd_i.w_pick) begin
      ram_we    = 1'b1;
      ram_wdata = '{free: 1'b0, size: granted};
    end else if (cmd_i.merge) begin
      ram_we = 1'b1;
      unique case ({prev_free_q, nxt_free_q})
        2'b11: begin
          ram_waddr = pick_m1[AW-1:0];
          ram_wdata = '{free: 1'b1, size: prev_sz_q + pick_sz_q + nxt_sz_q};
        end
        2'b10: begin
          ram_waddr = pick_m1[AW-1:0];
          ram_wdata = '{free: 1'b1, size: prev_sz_q + pick_sz_q};
        end
        2'b01: ram_wdata = '{free: 1'b1, size: pick_sz_q + nxt_sz_q};
        default: ram_wdata = '{free: 1'b1, size: pick_sz_q};
      endcase
    end else begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= '0;
      need_q      <= '0;
      target_q    <= '0;
      count_q     <= CW'(1);
      live_q      <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      pool_q      <= spa_pkg::PoolReset;
      scan_q      <= '0;
      chk_v_q     <= 1'b0;
      chk_idx_q   <= '0;
      cur_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      pick_sz_q   <= '0;
      pick_off_q  <= '0;
      mark_q      <= '0;
      prev_free_q <= 1'b0;
      prev_sz_q   <= '0;
      nxt_free_q  <= 1'b0;
      nxt_sz_q    <= '0;
      has_next_q  <= 1'b0;
      split_q     <= 1'b0;
      up_q        <= 1'b0;
      src_q       <= '0;
      dst_q       <= '0;
      lim_q       <= '0;
      res_q       <= '0;
      res_v_q     <= 1'b0;
    end else begin
      res_v_q <= 1'b0;
      if (cmd_i.load) begin
        kind_q      <= req_i.kind;
        need_q      <= need_c;
        target_q    <= req_i.free_offset;
        scan_q      <= '0;
        chk_v_q     <= 1'b0;
        cur_q       <= '0;
        found_q     <= 1'b0;
        mark_q      <= '0;
        prev_free_q <= 1'b0;
        nxt_free_q  <= 1'b0;
        split_q     <= 1'b0;
        up_q        <= 1'b0;
        src_q       <= '0;
        lim_q       <= '0;
      end
      if (cmd_i.scan) begin
        if (scan_q < count_q) begin
          chk_v_q   <= 1'b1;
          chk_idx_q <= scan_q;
          scan_q    <= scan_q + CW'(1);
        end else begin
          chk_v_q <= 1'b0;
        end
        if (chk_v_q) begin
          cur_q <= cur_q + ent.size;
          if (hit) begin
            found_q    <= 1'b1;
            pick_q     <= chk_idx_q;
            pick_sz_q  <= ent.size;
            pick_off_q <= cur_q;
            mark_q     <= ent.size;
          end
          if (!is_alloc && !match) begin
            prev_free_q <= ent.free;
            prev_sz_q   <= ent.size;
          end
        end
      end
      if (cmd_i.decide) begin
        split_q <= split_ok && found_q && is_alloc;
        if (split_ok && found_q && is_alloc) begin
          up_q  <= 1'b1;
          dst_q <= count_q;
          src_q <= count_q - CW'(1);
          lim_q <= pick_p1;
        end
      end
      if (cmd_i.copy_wr) begin
        if (up_q) begin
          dst_q <= dst_q - CW'(1);
          src_q <= src_q - CW'(1);
        end else begin
          dst_q <= dst_q + CW'(1);
          src_q <= src_q + CW'(1);
        end
      end
      if (cmd_i.w_pick) begin
        used_q  <= used_add;
        live_q  <= live_q + CW'(1);
        count_q <= count_q + CW'(split_q);
        if (used_add > peak_q) begin
          peak_q <= used_add;
        end
      end
      if (cmd_i.next_rd) begin
        has_next_q <= (pick_p1 < count_q);
      end
      if (cmd_i.next_wt) begin
        nxt_free_q <= has_next_q && ent.free;
        nxt_sz_q   <= ent.size;
      end
      if (cmd_i.merge) begin
        used_q <= used_q - pick_sz_q;
        live_q <= live_q - CW'(1);
        up_q   <= 1'b0;
        lim_q  <= count_q;
        unique case ({prev_free_q, nxt_free_q})
          2'b11: begin
            dst_q   <= pick_q;
            src_q   <= pick_p2;
            count_q <= count_q - CW'(2);
          end
          2'b10: begin
            dst_q   <= pick_q;
            src_q   <= pick_p1;
            count_q <= count_q - CW'(1);
          end
          2'b01: begin
            dst_q   <= pick_p1;
            src_q   <= pick_p2;
            count_q <= count_q - CW'(1);
          end
          default: begin
            dst_q <= pick_q;
            src_q <= pick_q;
          end
        endcase
      end
      if (cmd_i.pool_rst) begin
        pool_q  <= pool_new;
        used_q  <= '0;
        live_q  <= '0;
        count_q <= CW'(1);
      end
      if (cmd_i.done) begin
        res_v_q                <= 1'b1;
        res_q.status           <= cmd_i.code;
        res_q.alloc_offset     <= (cmd_i.code == spa_pkg::ST_OK && is_alloc)
                                  ? pick_off_q[spa_pkg::OffW-1:0] : '0;
        res_q.used_bytes       <= used_q;
        res_q.available_bytes  <= pool_q - used_q;
        res_q.live_allocations <= spa_pkg::LiveW'(live_q);
        res_q.peak_bytes       <= peak_q;
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_v_q;

endmodule

// File: hdl/segment_pool_allocator.sv
// Channel   Ports                                Handshake
// request   start, busy, req_i                  taken when start is high and busy is low
// result    res_valid_o, res_o                  shown for one cycle, no backpressure
// config    psel, penable, pwrite, paddr,       APB, written in the access phase,
//           pwdata, prdata, pready              pready tied high
//
// Per request: allocate or free scans the segment table one entry a cycle,
// then moves table entries one at a time through the RAM, reading each and
// then writing it back; a split or merge near the table head moves the most
// entries. The result strobe comes in the first cycle with busy low. After
// reset the block is busy while it writes table entry zero. The receiver
// cannot stall; configuration must be written only while idle, which the
// block itself does not enforce.
module segment_pool_allocator #(
  parameter int unsigned MAX_SEGMENTS = spa_pkg::MaxSegments,
  parameter int unsigned SPLIT_MIN    = spa_pkg::SplitMin
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  spa_pkg::req_t               req_i,
  output logic                        res_valid_o,
  output spa_pkg::res_t               res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [1:0]                 fit_q;
  logic [spa_pkg::SizeW-1:0]  pool_cfg_q;
  logic [spa_pkg::AlignW-1:0] align_q;
  logic                       cfg_we;
  spa_pkg::reg_e              reg_sel;
  spa_pkg::cmd_t              cmd;
  spa_pkg::stat_t             stat;

  assign pready  = 1'b1;
  assign reg_sel = spa_pkg::reg_e'(paddr[3:2]);
  // Commit a write in the access phase.
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q      <= spa_pkg::FIT_FIRST;
      pool_cfg_q <= spa_pkg::PoolReset;
      align_q    <= spa_pkg::AlignReset;
    end else if (cfg_we) begin
      unique case (reg_sel)
        spa_pkg::REG_FIT:   fit_q      <= pwdata[1:0];
        spa_pkg::REG_POOL:  pool_cfg_q <= pwdata[spa_pkg::SizeW-1:0];
        spa_pkg::REG_ALIGN: align_q    <= pwdata[spa_pkg::AlignW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      spa_pkg::REG_FIT:   prdata = 32'(fit_q);
      spa_pkg::REG_POOL:  prdata = 32'(pool_cfg_q);
      spa_pkg::REG_ALIGN: prdata = 32'(align_q);
      default:            prdata = '0;
    endcase
  end

  // Sequence the request: scan, move entries, write back, report.
  spa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .st_i   (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold the segment table, counters and result register.
  spa_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SPLIT_MIN    (SPLIT_MIN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .fit_i       (fit_q),
    .pool_cfg_i  (pool_cfg_q),
    .align_cfg_i (align_q),
    .cmd_i       (cmd),
    .st_o        (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// File: hdl/spa_checker.sv
module spa_props (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input spa_pkg::res_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_err_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != spa_pkg::ST_OK) |-> (res_o.alloc_offset == '0))
    else $error("failed request reports an offset");

endmodule

bind segment_pool_allocator spa_props u_spa_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// File: sim/spa_checker.sv
module spa_checker
  import spa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  req_t             req_i,
  input  logic             res_valid_o,
  input  res_t             res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  fit_e              fit_mode;
  logic [SizeW-1:0]  pool_setting;
  logic [AlignW-1:0] dflt_align;

  // segment table copy
  logic [SizeW-1:0] seg_size [MaxSegments];
  logic             seg_free [MaxSegments];
  int unsigned      seg_count;
  logic [SizeW-1:0] used_sum;
  logic [LiveW-1:0] live_num;
  logic [SizeW-1:0] peak_sum;
  logic [SizeW-1:0] pool_size;

  res_t expected_results[$];

  function automatic void clear_table();
    foreach (seg_size[k]) begin
      seg_size[k] = '0;
      seg_free[k] = 1'b0;
    end
    seg_size[0] = pool_size;
    seg_free[0] = 1'b1;
    seg_count   = 1;
    used_sum    = '0;
    live_num    = '0;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < seg_count; k++) begin
      seg_size[k] = seg_size[k+1];
      seg_free[k] = seg_free[k+1];
    end
    seg_count--;
  endfunction

  function automatic logic [1:0] grant(input req_t r, output logic [OffW-1:0] off);
    longint unsigned a, need, mark, sum;
    int unsigned pick;
    off = '0;
    if (r.request_bytes == 0) return ST_INVALID;
    a = (r.alignment != 0) ? r.alignment : dflt_align;
    if (a == 0) a = 1;
    need = (longint'(r.request_bytes) + a - 1) & ~(a - 1);
    pick = seg_count;
    mark = 0;
    for (int unsigned k = 0; k < seg_count; k++) begin
      if (!seg_free[k] || longint'(seg_size[k]) < need) continue;
      if (fit_mode == FIT_FIRST) begin
        pick = k;
        break;
      end else if (fit_mode == FIT_BEST) begin
        if (pick == seg_count || seg_size[k] < mark) begin
          pick = k;
          mark = seg_size[k];
        end
      end else if (fit_mode == FIT_WORST) begin
        if (seg_size[k] > mark) begin
          pick = k;
          mark = seg_size[k];
        end
      end
    end
    if (pick == seg_count) return ST_NOMEM;
    // split off the tail when the excess is worth a table entry
    if (longint'(seg_size[pick]) > need + SplitMin && seg_count < MaxSegments) begin
      for (int unsigned k = seg_count; k > pick + 1; k--) begin
        seg_size[k] = seg_size[k-1];
        seg_free[k] = seg_free[k-1];
      end
      seg_size[pick+1] = seg_size[pick] - SizeW'(need);
      seg_free[pick+1] = 1'b1;
      seg_size[pick]   = SizeW'(need);
      seg_count++;
    end
    seg_free[pick] = 1'b0;
    sum = 0;
    for (int unsigned k = 0; k < pick; k++) sum += seg_size[k];
    off = OffW'(sum);
    used_sum += seg_size[pick];
    live_num++;
    if (used_sum > peak_sum) peak_sum = used_sum;
    return ST_OK;
  endfunction

  function automatic logic [1:0] release_at(input logic [OffW-1:0] target);
    longint unsigned cur;
    cur = 0;
    for (int unsigned k = 0; k < seg_count; k++) begin
      if (cur == target && !seg_free[k]) begin
        seg_free[k] = 1'b1;
        used_sum -= seg_size[k];
        live_num--;
        if (k > 0 && seg_free[k-1]) begin
          seg_size[k-1] += seg_size[k];
          drop_entry(k);
          k--;
        end
        if (k + 1 < seg_count && seg_free[k+1]) begin
          seg_size[k] += seg_size[k+1];
          drop_entry(k + 1);
        end
        return ST_OK;
      end
      cur += seg_size[k];
    end
    return ST_INVALID;
  endfunction

  function automatic res_t predict_outcome(input req_t r);
    res_t o;
    logic [OffW-1:0] off;
    o = '0;
    off = '0;
    case (kind_e'(r.kind))
      KIND_ALLOC: o.status = grant(r, off);
      KIND_FREE:  o.status = release_at(r.free_offset);
      KIND_RESET: begin
        pool_size = pool_setting;
        if (pool_size == 0) pool_size = 1;
        if (pool_size > PoolLimit) pool_size = PoolLimit;
        clear_table();
        o.status = ST_OK;
      end
      default:    o.status = ST_INVALID;
    endcase
    o.alloc_offset     = (o.status == ST_OK) ? off : '0;
    o.used_bytes       = used_sum;
    o.available_bytes  = pool_size - used_sum;
    o.live_allocations = live_num;
    o.peak_bytes       = peak_sum;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      fit_mode     = FIT_FIRST;
      pool_setting = PoolReset;
      dflt_align   = AlignReset;
      pool_size    = PoolReset;
      peak_sum     = '0;
      clear_table();
      expected_results.delete();
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_o.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res_o.status);
            fail_count++;
          end
          if (res_o.alloc_offset !== exp_r.alloc_offset) begin
            $error("alloc_offset: expected %0d, got %0d",
                   exp_r.alloc_offset, res_o.alloc_offset);
            fail_count++;
          end
          if (res_o.used_bytes !== exp_r.used_bytes) begin
            $error("used_bytes: expected %0d, got %0d", exp_r.used_bytes, res_o.used_bytes);
            fail_count++;
          end
          if (res_o.available_bytes !== exp_r.available_bytes) begin
            $error("available_bytes: expected %0d, got %0d",
                   exp_r.available_bytes, res_o.available_bytes);
            fail_count++;
          end
          if (res_o.live_allocations !== exp_r.live_allocations) begin
            $error("live_allocations: expected %0d, got %0d",
                   exp_r.live_allocations, res_o.live_allocations);
            fail_count++;
          end
          if (res_o.peak_bytes !== exp_r.peak_bytes) begin
            $error("peak_bytes: expected %0d, got %0d", exp_r.peak_bytes, res_o.peak_bytes);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_outcome(req_i));
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_FIT:   fit_mode     = fit_e'(pwdata[1:0]);
          REG_POOL:  pool_setting = pwdata[SizeW-1:0];
          REG_ALIGN: dflt_align   = pwdata[AlignW-1:0];
          default:   ;
        endcase
      end
      pending = expected_results.size();
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import spa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 4000;
  localparam int RandomItems = 175;

  logic             clk_i, rst_ni, start, busy, res_valid_o;
  req_t             req_i;
  res_t             res_o;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata, prdata;
  int               fail_count, pending;

  // requests in flight, so the result monitor knows what each result answers
  req_t             inflight[$];
  logic [OffW-1:0]  live_offsets[$];
  int               request_total, grant_total, quiet_cycles;

  segment_pool_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spa_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Track granted offsets so most frees hit a live segment.
  always @(posedge clk_i) begin
    req_t r;
    if (rst_ni) begin
      if (res_valid_o && inflight.size() != 0) begin
        r = inflight.pop_front();
        if (r.kind == KIND_ALLOC && res_o.status == ST_OK) begin
          live_offsets.push_back(res_o.alloc_offset);
          grant_total++;
        end else if (r.kind == KIND_FREE && res_o.status == ST_OK) begin
          foreach (live_offsets[i]) begin
            if (live_offsets[i] == r.free_offset) begin
              live_offsets.delete(i);
              break;
            end
          end
        end else if (r.kind == KIND_RESET) begin
          live_offsets.delete();
        end
      end
      if (start && !busy) begin
        inflight.push_back(req_i);
        request_total++;
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one request, idling first with the given odds; hold start high
  // afterwards so back-to-back requests stay back to back.
  task automatic send(input req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic req_t make_req(input kind_e k, input int unsigned bytes,
                                    input int unsigned align, input int unsigned off);
    req_t r;
    r.kind          = k;
    r.request_bytes = SizeW'(bytes);
    r.alignment     = AlignW'(align);
    r.free_offset   = OffW'(off);
    return r;
  endfunction

  // Drain outstanding results, let the block settle, then write one register.
  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = AddrW'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random request: mostly allocate and free of live segments, with
  // some resets, unmatched frees, zero sizes and the unused kind mixed in.
  function automatic req_t random_req();
    int unsigned roll, bytes, align, off;
    roll  = $urandom_range(99);
    bytes = $urandom_range(99) < 70 ? $urandom_range(512, 1) :
            $urandom_range(99) < 70 ? $urandom_range(8192, 1) :
            $urandom_range(99) < 80 ? $urandom_range(300000, 1) : $urandom;
    case ($urandom_range(4))
      0, 1:    align = 0;
      2:       align = 1 << $urandom_range(12);
      3:       align = $urandom_range(4096);
      default: align = $urandom;
    endcase
    off = $urandom;
    if (roll < 55) return make_req(KIND_ALLOC, bytes, align, off);
    if (roll < 90) begin
      if (live_offsets.size() != 0 && $urandom_range(9) != 0)
        off = live_offsets[$urandom_range(live_offsets.size() - 1)];
      return make_req(KIND_FREE, bytes, align, off);
    end
    if (roll < 94) return make_req(KIND_RESET, bytes, align, off);
    if (roll < 97) return make_req(KIND_ALLOC, 0, align, off);
    return make_req(KIND_BAD, bytes, align, off);
  endfunction

  initial begin
    logic [31:0] fit_set   [6] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_NONE, FIT_BEST,
                                   FIT_FIRST};
    logic [31:0] pool_set  [6] = '{4096, 65536, 16777216, 0, 32'h1FF_FFFF, 1048576};
    logic [31:0] align_set [6] = '{64, 1, 4096, 0, 100, 8191};
    int idle_pct;

    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    quiet_cycles = 0;
    request_total = 0;
    grant_total = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: invalid size, default and explicit alignment, odd alignment,
    // oversize, merge on both sides, unmatched free, unused kind, reset.
    send(make_req(KIND_ALLOC, 0, 0, 0), 0);
    send(make_req(KIND_ALLOC, 100, 0, 0), 0);            // 128 at 0
    send(make_req(KIND_ALLOC, 100, 0, 0), 0);            // 128 at 128
    send(make_req(KIND_ALLOC, 100, 0, 0), 0);            // 128 at 256
    send(make_req(KIND_FREE, 0, 0, 0), 0);
    send(make_req(KIND_FREE, 0, 0, 256), 0);
    send(make_req(KIND_FREE, 0, 0, 128), 0);             // merge with both neighbors
    send(make_req(KIND_ALLOC, 1, 1, 0), 0);
    send(make_req(KIND_ALLOC, 1, 4096, 0), 0);
    send(make_req(KIND_ALLOC, 5, 3, 0), 0);
    send(make_req(KIND_ALLOC, 7, 8191, 0), 0);
    send(make_req(KIND_ALLOC, 16777216, 0, 0), 0);       // out of memory
    send(make_req(KIND_ALLOC, 32'h1FF_FFFF, 8191, 0), 0);
    send(make_req(KIND_FREE, 0, 0, 24'hFF_FFFF), 0);     // unmatched
    send(make_req(KIND_FREE, 0, 0, 0), 0);
    send(make_req(KIND_FREE, 0, 0, 0), 0);               // already free
    send(make_req(KIND_BAD, 32'h1FF_FFFF, 13'h1FFF, 24'hFF_FFFF), 0);
    send(make_req(KIND_RESET, 0, 0, 0), 0);
    send(make_req(KIND_ALLOC, 1048576, 0, 0), 0);        // whole pool
    send(make_req(KIND_ALLOC, 1, 0, 0), 0);
    send(make_req(KIND_RESET, 0, 0, 0), 0);

    // Random phases: sender idles 29 percent, then 76, then not at all.
    for (int s = 0; s < 6; s++) begin
      idle_pct = (s == 0) ? 29 : (s == 1) ? 76 : 0;
      write_reg(REG_FIT, fit_set[s]);
      write_reg(REG_POOL, pool_set[s]);
      write_reg(REG_ALIGN, align_set[s]);
      send(make_req(KIND_RESET, 0, 0, 0), idle_pct);     // take the new pool size
      for (int n = 0; n < RandomItems; n++) send(random_req(), idle_pct);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);

    $display("Covered %0d requests over six register settings (all fit modes,",
             request_total);
    $display("pool and alignment extremes); %0d allocations granted.", grant_total);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
